// ===== src/mpcl_pkg.sv =====
// Package for the mixed particle cluster labeler.
// Shared constants, action and result codes, and register indexes.
// No dependencies.
`default_nettype none

package mpcl_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int ADDR_W        = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = ADDR_W + 1;
    localparam int HIST_DEPTH    = MAX_PARTICLES + 1;
    localparam int HIST_AW       = $clog2(HIST_DEPTH);
    localparam int COORD_BITS    = 24;
    localparam int KIND_W        = 2;
    localparam int BOX_W         = 23;
    localparam int CRIT_W        = 40;
    localparam int BIN_W         = 32;
    localparam int FAR_BITS      = 20;
    localparam int DIFF_W        = COORD_BITS + 3;
    localparam int SQ_W          = 2 * FAR_BITS;
    localparam int SUM_W         = SQ_W + 2;
    localparam int PART_W        = 3 * COORD_BITS + KIND_W;
    localparam int NODE_W        = CNT_W + 1;

    localparam logic [BOX_W-1:0]  BOX_RESET  = BOX_W'(2560);
    localparam logic [CRIT_W-1:0] CRIT_RESET = CRIT_W'(289014);

    localparam logic [1:0] ACT_LOAD       = 2'd0;
    localparam logic [1:0] ACT_READ_LABEL = 2'd1;
    localparam logic [1:0] ACT_READ_BIN   = 2'd2;
    localparam logic [1:0] ACT_CLEAR_HIST = 2'd3;

    localparam logic [1:0] RES_SUMMARY = 2'd0;
    localparam logic [1:0] RES_LABEL   = 2'd1;
    localparam logic [1:0] RES_BIN     = 2'd2;

    localparam logic REG_BOX_LENGTH   = 1'b0;
    localparam logic REG_CRIT_DIST_SQ = 1'b1;

endpackage

`default_nettype wire

// ===== src/mpcl_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module mpcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/mixed_particle_cluster_labeler.sv =====
// Frame analysis: a clear sweep over the frame's particles, then for each center
// particle one scan of the particle RAM through the distance pipeline, plus a
// label-dropping sweep per unmixed cluster; the scans set the worst case.
// Reset: synchronous active-low; a histogram clearing pass over every bin
// follows reset, during which no word is accepted (config writes are always taken).
`default_nettype none

module mixed_particle_cluster_labeler
    import mpcl_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [1:0]                   i_action,
    input  wire logic signed [COORD_BITS-1:0] i_pos_x,
    input  wire logic signed [COORD_BITS-1:0] i_pos_y,
    input  wire logic signed [COORD_BITS-1:0] i_pos_z,
    input  wire logic [KIND_W-1:0]            i_kind,
    input  wire logic                         i_last_particle,
    input  wire logic [CNT_W-1:0]             i_lookup_index,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [CNT_W-1:0]                  o_cluster_count,
    output logic [CNT_W-1:0]                  o_biggest_size,
    output logic [CNT_W-1:0]                  o_biggest_label,
    output logic [CNT_W-1:0]                  o_particle_label,
    output logic [BIN_W-1:0]                  o_bin_count,
    output logic [1:0]                        o_result_kind,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic                         i_cfg_index,
    input  wire logic [CRIT_W-1:0]            i_cfg_data
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_HCLR     = 16'h0002,
        S_RDL      = 16'h0004,
        S_RDH      = 16'h0008,
        S_CLR      = 16'h0010,
        S_ROOT_RD  = 16'h0020,
        S_ROOT_CHK = 16'h0040,
        S_POP      = 16'h0080,
        S_POP_WAIT = 16'h0100,
        S_CEN_WAIT = 16'h0200,
        S_SCAN     = 16'h0400,
        S_DRAIN    = 16'h0800,
        S_CLOSE    = 16'h1000,
        S_HIST_WR  = 16'h2000,
        S_UNK      = 16'h4000,
        S_FINISH   = 16'h8000
    } t_state;

    // ---------------- control registers ----------------
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;           // particles loaded this frame
    logic [CNT_W-1:0] r_n, n_n;               // particles in the frame under analysis
    logic [CNT_W-1:0] r_last_n, n_last_n;     // particles with readable labels
    logic [CNT_W-1:0] r_a, n_a;               // sweep / scan pointer
    logic [CNT_W-1:0] r_i, n_i;               // root candidate
    logic [CNT_W-1:0] r_top, n_top;           // stack depth
    logic [CNT_W-1:0] r_label, n_label;       // next label to give out
    logic [CNT_W-1:0] r_size, n_size;         // members of the open cluster
    logic [CNT_W-1:0] r_big_size, n_big_size;
    logic [CNT_W-1:0] r_big_label, n_big_label;
    logic             r_mixed, n_mixed;
    logic             r_rd_ok, n_rd_ok;
    logic [KIND_W-1:0] r_root_kind, n_root_kind;
    logic [BOX_W-1:0]  r_box;
    logic [CRIT_W-1:0] r_crit;
    logic              r_uv, n_uv;             // unkeep sweep read in flight

    // center particle of the current scan
    logic signed [COORD_BITS-1:0] r_cen [3];
    logic signed [COORD_BITS-1:0] n_cen [3];

    // output word
    logic             r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_o_count, n_o_count, r_o_bsize, n_o_bsize, r_o_blabel, n_o_blabel;
    logic [CNT_W-1:0] r_o_plabel, n_o_plabel;
    logic [BIN_W-1:0] r_o_bin, n_o_bin;
    logic [1:0]       r_o_kind, n_o_kind;

    // ---------------- memories ----------------
    logic              part_we;
    logic [ADDR_W-1:0] part_waddr, part_raddr;
    logic [PART_W-1:0] part_wdata, part_rdata;
    logic              node_we;
    logic [ADDR_W-1:0] node_waddr, node_raddr;
    logic [NODE_W-1:0] node_wdata, node_rdata;
    logic              stk_we;
    logic [ADDR_W-1:0] stk_waddr, stk_raddr;
    logic [ADDR_W-1:0] stk_wdata, stk_rdata;
    logic               hist_we;
    logic [HIST_AW-1:0] hist_waddr, hist_raddr;
    logic [BIN_W-1:0]   hist_wdata, hist_rdata;

    // positions and kind, {kind, z, y, x}
    mpcl_ram #(.WIDTH(PART_W), .DEPTH(MAX_PARTICLES)) u_part_ram (
        .i_clk(i_clk), .i_we(part_we), .i_waddr(part_waddr), .i_wdata(part_wdata),
        .i_raddr(part_raddr), .o_rdata(part_rdata)
    );
    // visited flag and label, {visited, label}
    mpcl_ram #(.WIDTH(NODE_W), .DEPTH(MAX_PARTICLES)) u_node_ram (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_raddr(node_raddr), .o_rdata(node_rdata)
    );
    // depth-first search stack
    mpcl_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_PARTICLES)) u_stack_ram (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );
    // cluster size histogram, persists across frames
    mpcl_ram #(.WIDTH(BIN_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
        .i_clk(i_clk), .i_we(hist_we), .i_waddr(hist_waddr), .i_wdata(hist_wdata),
        .i_raddr(hist_raddr), .o_rdata(hist_rdata)
    );

    // ---------------- distance pipeline ----------------
    // Stage 1 is the RAM read. A: difference and upper wrap. B: lower wrap,
    // magnitude, far test. C: squares. D: sum and compare, decides the link.
    logic              issue;
    logic              r_v1, r_vA, r_vB, r_vC;
    logic [ADDR_W-1:0] r_a1, r_aA, r_aB, r_aC;
    logic [KIND_W-1:0] r_kA, r_kB, r_kC;
    logic signed [DIFF_W-1:0] r_dA [3];
    logic signed [DIFF_W-1:0] dA_n [3];
    logic [FAR_BITS-1:0] r_absB [3];
    logic [FAR_BITS-1:0] absB_n [3];
    logic                r_farB, r_farC, farB_n;
    logic [SQ_W-1:0]     r_sqC [3];
    logic [SUM_W-1:0]    sum_d;
    logic                link;
    logic signed [DIFF_W-1:0] box_s;

    assign box_s = $signed({{(DIFF_W-BOX_W){1'b0}}, r_box});

    always_comb begin
        logic signed [DIFF_W-1:0] pos_o, pos_c, d;
        logic signed [DIFF_W-1:0] e;
        logic [DIFF_W-1:0]        mag;
        farB_n = 1'b0;
        for (int k = 0; k < 3; k++) begin
            pos_o = DIFF_W'($signed(part_rdata[k*COORD_BITS +: COORD_BITS]));
            pos_c = DIFF_W'(r_cen[k]);
            d = pos_c - pos_o;
            if ((d <<< 1) > box_s) begin
                d = d - box_s;
            end
            dA_n[k] = d;
            e = r_dA[k];
            if ((e <<< 1) < -box_s) begin
                e = e + box_s;
            end
            mag = (e < 0) ? DIFF_W'(-e) : DIFF_W'(e);
            if (mag[DIFF_W-1:FAR_BITS] != '0) begin
                farB_n = 1'b1;
            end
            absB_n[k] = mag[FAR_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_vA <= 1'b0;
            r_vB <= 1'b0;
            r_vC <= 1'b0;
        end else begin
            r_v1 <= issue;
            // drop already visited particles as they leave the RAM
            r_vA <= r_v1 && !node_rdata[NODE_W-1];
            r_vB <= r_vA;
            r_vC <= r_vB;
        end
        r_a1   <= r_a[ADDR_W-1:0];
        r_aA   <= r_a1;
        r_aB   <= r_aA;
        r_aC   <= r_aB;
        r_kA   <= part_rdata[PART_W-1 -: KIND_W];
        r_kB   <= r_kA;
        r_kC   <= r_kB;
        r_farB <= farB_n;
        r_farC <= r_farB;
        for (int k = 0; k < 3; k++) begin
            r_dA[k]   <= dA_n[k];
            r_absB[k] <= absB_n[k];
            r_sqC[k]  <= r_absB[k] * r_absB[k];
        end
    end

    assign sum_d = SUM_W'(r_sqC[0]) + SUM_W'(r_sqC[1]) + SUM_W'(r_sqC[2]);
    assign link  = r_vC && !r_farC && (sum_d <= SUM_W'(r_crit));

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box  <= BOX_RESET;
            r_crit <= CRIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BOX_LENGTH:   r_box  <= i_cfg_data[BOX_W-1:0];
                REG_CRIT_DIST_SQ: r_crit <= i_cfg_data;
                default:          r_box  <= r_box;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    logic             accept;
    logic [CNT_W-1:0] i_next;
    logic             roots_done;

    // Loads that end no frame make no result, so take them even while
    // a result word waits.
    assign o_ready = (r_state == S_IDLE) &&
                     (!r_out_valid || (i_action == ACT_LOAD && !i_last_particle));
    assign accept     = i_valid && o_ready;
    assign i_next     = r_i + CNT_W'(1);
    assign roots_done = (i_next == r_n);
    assign issue      = (r_state == S_SCAN);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_last_n    = r_last_n;
        n_a         = r_a;
        n_i         = r_i;
        n_top       = r_top;
        n_label     = r_label;
        n_size      = r_size;
        n_big_size  = r_big_size;
        n_big_label = r_big_label;
        n_mixed     = r_mixed;
        n_rd_ok     = r_rd_ok;
        n_root_kind = r_root_kind;
        n_uv        = 1'b0;
        n_cen       = r_cen;
        n_out_valid = r_out_valid && !i_ready;
        n_o_count   = r_o_count;
        n_o_bsize   = r_o_bsize;
        n_o_blabel  = r_o_blabel;
        n_o_plabel  = r_o_plabel;
        n_o_bin     = r_o_bin;
        n_o_kind    = r_o_kind;

        part_we    = 1'b0;
        part_waddr = r_cnt[ADDR_W-1:0];
        part_wdata = {i_kind, i_pos_z, i_pos_y, i_pos_x};
        part_raddr = r_a[ADDR_W-1:0];
        node_we    = 1'b0;
        node_waddr = r_a[ADDR_W-1:0];
        node_wdata = '0;
        node_raddr = r_a[ADDR_W-1:0];
        stk_we     = 1'b0;
        stk_waddr  = r_top[ADDR_W-1:0];
        stk_wdata  = r_aC;
        stk_raddr  = r_top[ADDR_W-1:0];
        hist_we    = 1'b0;
        hist_waddr = r_a[HIST_AW-1:0];
        hist_wdata = '0;
        hist_raddr = i_lookup_index[HIST_AW-1:0];

        // link found at the end of the distance pipeline: mark, label, push
        if (link) begin
            node_we    = 1'b1;
            node_waddr = r_aC;
            node_wdata = {1'b1, r_label};
            stk_we     = 1'b1;
            n_top      = r_top + CNT_W'(1);
            n_size     = r_size + CNT_W'(1);
            if (r_kC != r_root_kind) begin
                n_mixed = 1'b1;
            end
        end

        case (r_state)
            S_IDLE: begin
                node_raddr = i_lookup_index[ADDR_W-1:0];
                if (accept) begin
                    case (i_action)
                        ACT_LOAD: begin
                            if (r_cnt < CNT_W'(MAX_PARTICLES)) begin
                                part_we = 1'b1;
                                n_cnt   = r_cnt + CNT_W'(1);
                            end
                            if (i_last_particle) begin
                                n_n     = (r_cnt < CNT_W'(MAX_PARTICLES)) ?
                                          r_cnt + CNT_W'(1) : r_cnt;
                                n_a     = '0;
                                n_state = S_CLR;
                            end
                        end
                        ACT_READ_LABEL: begin
                            n_rd_ok = (i_lookup_index < r_last_n);
                            n_state = S_RDL;
                        end
                        ACT_READ_BIN: begin
                            n_rd_ok = (i_lookup_index <= CNT_W'(MAX_PARTICLES));
                            n_state = S_RDH;
                        end
                        ACT_CLEAR_HIST: begin
                            n_a     = '0;
                            n_state = S_HCLR;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_HCLR: begin
                hist_we = 1'b1;
                n_a     = r_a + CNT_W'(1);
                if (r_a == CNT_W'(HIST_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_RDL: begin
                n_out_valid = 1'b1;
                n_o_count   = '0;
                n_o_bsize   = '0;
                n_o_blabel  = '0;
                n_o_bin     = '0;
                n_o_plabel  = r_rd_ok ? node_rdata[CNT_W-1:0] : '0;
                n_o_kind    = RES_LABEL;
                n_state     = S_IDLE;
            end
            S_RDH: begin
                n_out_valid = 1'b1;
                n_o_count   = '0;
                n_o_bsize   = '0;
                n_o_blabel  = '0;
                n_o_plabel  = '0;
                n_o_bin     = r_rd_ok ? hist_rdata : '0;
                n_o_kind    = RES_BIN;
                n_state     = S_IDLE;
            end
            S_CLR: begin
                // clear visited flags and labels of this frame's particles
                node_we     = 1'b1;
                n_a         = r_a + CNT_W'(1);
                n_label     = CNT_W'(1);
                n_big_size  = CNT_W'(1);
                n_big_label = '0;
                if (n_a == r_n) begin
                    n_i     = '0;
                    n_state = S_ROOT_RD;
                end
            end
            S_ROOT_RD: begin
                node_raddr = r_i[ADDR_W-1:0];
                part_raddr = r_i[ADDR_W-1:0];
                n_state    = S_ROOT_CHK;
            end
            S_ROOT_CHK: begin
                if (node_rdata[NODE_W-1]) begin
                    n_i     = i_next;
                    n_state = roots_done ? S_FINISH : S_ROOT_RD;
                end else begin
                    node_we     = 1'b1;
                    node_waddr  = r_i[ADDR_W-1:0];
                    node_wdata  = {1'b1, r_label};
                    stk_we      = 1'b1;
                    stk_waddr   = '0;
                    stk_wdata   = r_i[ADDR_W-1:0];
                    n_top       = CNT_W'(1);
                    n_size      = CNT_W'(1);
                    n_mixed     = 1'b0;
                    n_root_kind = part_rdata[PART_W-1 -: KIND_W];
                    n_state     = S_POP;
                end
            end
            S_POP: begin
                stk_raddr = r_top[ADDR_W-1:0] - ADDR_W'(1);
                if (r_top == '0) begin
                    n_state = S_CLOSE;
                end else begin
                    n_top   = r_top - CNT_W'(1);
                    n_state = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                part_raddr = stk_rdata;
                n_state    = S_CEN_WAIT;
            end
            S_CEN_WAIT: begin
                for (int k = 0; k < 3; k++) begin
                    n_cen[k] = $signed(part_rdata[k*COORD_BITS +: COORD_BITS]);
                end
                n_a     = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                n_a = r_a + CNT_W'(1);
                if (n_a == r_n) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_vA && !r_vB && !r_vC) begin
                    n_state = S_POP;
                end
            end
            S_CLOSE: begin
                hist_raddr = r_size[HIST_AW-1:0];
                n_a        = '0;
                n_state    = r_mixed ? S_HIST_WR : S_UNK;
            end
            S_HIST_WR: begin
                hist_we    = 1'b1;
                hist_waddr = r_size[HIST_AW-1:0];
                hist_wdata = (hist_rdata == '1) ? hist_rdata : hist_rdata + BIN_W'(1);
                if (r_size > r_big_size) begin
                    n_big_size  = r_size;
                    n_big_label = r_label;
                end
                n_label = r_label + CNT_W'(1);
                n_i     = i_next;
                n_state = roots_done ? S_FINISH : S_ROOT_RD;
            end
            S_UNK: begin
                // drop the label of an unmixed cluster, keep its visited flag
                if (r_a != r_n) begin
                    n_uv = 1'b1;
                    n_a  = r_a + CNT_W'(1);
                end
                if (r_uv && node_rdata[CNT_W-1:0] == r_label) begin
                    node_we    = 1'b1;
                    node_waddr = r_a[ADDR_W-1:0] - ADDR_W'(1);
                    node_wdata = {1'b1, {CNT_W{1'b0}}};
                end
                if (r_a == r_n && !r_uv) begin
                    n_i     = i_next;
                    n_state = roots_done ? S_FINISH : S_ROOT_RD;
                end
            end
            S_FINISH: begin
                n_out_valid = 1'b1;
                n_o_count   = r_label - CNT_W'(1);
                n_o_bsize   = r_big_size;
                n_o_blabel  = r_big_label;
                n_o_plabel  = '0;
                n_o_bin     = '0;
                n_o_kind    = RES_SUMMARY;
                n_last_n    = r_n;
                n_cnt       = '0;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_HCLR;
            r_cnt       <= '0;
            r_n         <= '0;
            r_last_n    <= '0;
            r_a         <= '0;
            r_i         <= '0;
            r_top       <= '0;
            r_label     <= CNT_W'(1);
            r_size      <= '0;
            r_big_size  <= CNT_W'(1);
            r_big_label <= '0;
            r_mixed     <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_root_kind <= '0;
            r_uv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_n         <= n_n;
            r_last_n    <= n_last_n;
            r_a         <= n_a;
            r_i         <= n_i;
            r_top       <= n_top;
            r_label     <= n_label;
            r_size      <= n_size;
            r_big_size  <= n_big_size;
            r_big_label <= n_big_label;
            r_mixed     <= n_mixed;
            r_rd_ok     <= n_rd_ok;
            r_root_kind <= n_root_kind;
            r_uv        <= n_uv;
            r_out_valid <= n_out_valid;
        end
        r_cen      <= n_cen;
        r_o_count  <= n_o_count;
        r_o_bsize  <= n_o_bsize;
        r_o_blabel <= n_o_blabel;
        r_o_plabel <= n_o_plabel;
        r_o_bin    <= n_o_bin;
        r_o_kind   <= n_o_kind;
    end

    assign o_valid          = r_out_valid;
    assign o_cluster_count  = r_o_count;
    assign o_biggest_size   = r_o_bsize;
    assign o_biggest_label  = r_o_blabel;
    assign o_particle_label = r_o_plabel;
    assign o_bin_count      = r_o_bin;
    assign o_result_kind    = r_o_kind;

    // ---------------- assertions ----------------
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= r_n)
        else $error("search stack deeper than frame");

    a_link_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        link |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("link outside a scan");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_a < r_n))
        else $error("scan past frame end");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_o_kind != 2'd3))
        else $error("bad result kind");

endmodule

`default_nettype wire

// ===== dv/mpcl_checker.sv =====
// Scoreboard for the mixed particle cluster labeler: watches the input, result
// and register channels, predicts every result and compares field by field.
// Depends on mpcl_pkg.
module mpcl_checker
    import mpcl_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic                         o_ready,
    input  wire logic [1:0]                   i_action,
    input  wire logic signed [COORD_BITS-1:0] i_pos_x,
    input  wire logic signed [COORD_BITS-1:0] i_pos_y,
    input  wire logic signed [COORD_BITS-1:0] i_pos_z,
    input  wire logic [KIND_W-1:0]            i_kind,
    input  wire logic                         i_last_particle,
    input  wire logic [CNT_W-1:0]             i_lookup_index,
    input  wire logic                         o_valid,
    input  wire logic                         i_ready,
    input  wire logic [CNT_W-1:0]             o_cluster_count,
    input  wire logic [CNT_W-1:0]             o_biggest_size,
    input  wire logic [CNT_W-1:0]             o_biggest_label,
    input  wire logic [CNT_W-1:0]             o_particle_label,
    input  wire logic [BIN_W-1:0]             o_bin_count,
    input  wire logic [1:0]                   o_result_kind,
    input  wire logic                         i_cfg_valid,
    input  wire logic                         o_cfg_ready,
    input  wire logic                         i_cfg_index,
    input  wire logic [CRIT_W-1:0]            i_cfg_data,
    output int                                o_errors,
    output int                                o_pending
);

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] big_size;
        logic [CNT_W-1:0] big_label;
        logic [CNT_W-1:0] plabel;
        logic [BIN_W-1:0] bin;
        logic [1:0]       kind;
    } t_answer;

    t_answer answers_due[$];

    logic signed [COORD_BITS-1:0] coord [MAX_PARTICLES][3];
    logic [KIND_W-1:0]            species [MAX_PARTICLES];
    bit                           seen [MAX_PARTICLES];
    int unsigned                  label_of [MAX_PARTICLES];
    int unsigned                  members [HIST_DEPTH];
    logic [BIN_W-1:0]             size_hist [HIST_DEPTH];
    int unsigned                  dfs_stack [MAX_PARTICLES];
    int unsigned                  loaded;
    logic [BOX_W-1:0]             box_len;
    logic [CRIT_W-1:0]            cutoff_sq;

    // Minimum-image neighbor test, one wrap per axis.
    function automatic bit near(int unsigned c, int unsigned o);
        longint d;
        longint box;
        longint unsigned sum;
        box = longint'(box_len);
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            d = longint'(coord[c][k]) - longint'(coord[o][k]);
            if (2 * d > box) d = d - box;
            if (2 * d < -box) d = d + box;
            if (d < 0) d = -d;
            if (d >= (longint'(1) << FAR_BITS)) return 1'b0;
            sum += longint'(d * d);
        end
        return sum <= longint'(cutoff_sq);
    endfunction

    function automatic t_answer label_frame();
        t_answer r;
        int unsigned n, top, c, nl, s;
        bit mixed;
        r = '0;
        n = loaded;
        nl = 1;
        for (int i = 0; i < MAX_PARTICLES; i++) begin
            seen[i] = 0;
            label_of[i] = 0;
        end
        for (int i = 0; i < HIST_DEPTH; i++) members[i] = 0;
        for (int i = 0; i < n; i++) begin
            if (seen[i]) continue;
            seen[i] = 1;
            label_of[i] = nl;
            mixed = 0;
            top = 0;
            dfs_stack[top++] = i;
            while (top > 0) begin
                c = dfs_stack[--top];
                for (int a = 0; a < n; a++) begin
                    if (a != c && !seen[a] && near(c, a)) begin
                        seen[a] = 1;
                        label_of[a] = nl;
                        if (species[a] != species[i]) mixed = 1;
                        if (top < MAX_PARTICLES) dfs_stack[top++] = a;
                    end
                end
            end
            if (!mixed) begin
                for (int a = 0; a < n; a++)
                    if (label_of[a] == nl) label_of[a] = 0;
            end else begin
                nl++;
            end
        end
        for (int i = 0; i < n; i++)
            if (label_of[i] > 0 && label_of[i] <= MAX_PARTICLES) members[label_of[i]]++;
        r.big_size = CNT_W'(1);
        for (int lab = 1; lab < nl && lab <= MAX_PARTICLES; lab++) begin
            s = members[lab];
            if (size_hist[s] != '1) size_hist[s]++;
            if (s > r.big_size) begin
                r.big_size = CNT_W'(s);
                r.big_label = CNT_W'(lab);
            end
        end
        r.count = CNT_W'(nl - 1);
        r.kind = RES_SUMMARY;
        return r;
    endfunction

    task automatic report(input string what, input longint unsigned got, input longint unsigned want);
        $display("%0t: %s got %0d want %0d", $time, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) size_hist[i] = '0;
            for (int i = 0; i < MAX_PARTICLES; i++) label_of[i] = 0;
            loaded = 0;
            box_len = BOX_RESET;
            cutoff_sq = CRIT_RESET;
            answers_due.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_BOX_LENGTH) box_len = i_cfg_data[BOX_W-1:0];
                else cutoff_sq = i_cfg_data;
            end
            if (i_valid && o_ready) begin
                want = '0;
                case (i_action)
                    ACT_LOAD: begin
                        if (loaded < MAX_PARTICLES) begin
                            coord[loaded][0] = i_pos_x;
                            coord[loaded][1] = i_pos_y;
                            coord[loaded][2] = i_pos_z;
                            species[loaded] = i_kind;
                            loaded++;
                        end
                        if (i_last_particle) begin
                            answers_due.push_back(label_frame());
                            loaded = 0;
                        end
                    end
                    ACT_READ_LABEL: begin
                        if (i_lookup_index < MAX_PARTICLES)
                            want.plabel = CNT_W'(label_of[i_lookup_index[ADDR_W-1:0]]);
                        want.kind = RES_LABEL;
                        answers_due.push_back(want);
                    end
                    ACT_READ_BIN: begin
                        if (i_lookup_index <= MAX_PARTICLES)
                            want.bin = size_hist[i_lookup_index];
                        want.kind = RES_BIN;
                        answers_due.push_back(want);
                    end
                    ACT_CLEAR_HIST: begin
                        for (int i = 0; i < HIST_DEPTH; i++) size_hist[i] = '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (o_valid && i_ready) begin
                if (answers_due.size() == 0) begin
                    report("unexpected result, kind", o_result_kind, 0);
                end else begin
                    want = answers_due.pop_front();
                    if (o_result_kind != want.kind) report("result_kind", o_result_kind, want.kind);
                    if (o_cluster_count != want.count)
                        report("cluster_count", o_cluster_count, want.count);
                    if (o_biggest_size != want.big_size)
                        report("biggest_size", o_biggest_size, want.big_size);
                    if (o_biggest_label != want.big_label)
                        report("biggest_label", o_biggest_label, want.big_label);
                    if (o_particle_label != want.plabel)
                        report("particle_label", o_particle_label, want.plabel);
                    if (o_bin_count != want.bin) report("bin_count", o_bin_count, want.bin);
                end
            end
        end
        o_pending = answers_due.size();
    end

endmodule

// ===== dv/mixed_particle_cluster_labeler_tb.sv =====
// Top of the cluster labeler testbench: clock, reset, stimulus and verdict.
// Depends on mpcl_pkg, mixed_particle_cluster_labeler and mpcl_checker.
module mixed_particle_cluster_labeler_tb;
    import mpcl_pkg::*;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [1:0]                   i_action;
    logic signed [COORD_BITS-1:0] i_pos_x;
    logic signed [COORD_BITS-1:0] i_pos_y;
    logic signed [COORD_BITS-1:0] i_pos_z;
    logic [KIND_W-1:0]            i_kind;
    logic                         i_last_particle;
    logic [CNT_W-1:0]             i_lookup_index;
    logic                         o_valid;
    logic                         i_ready;
    logic [CNT_W-1:0]             o_cluster_count;
    logic [CNT_W-1:0]             o_biggest_size;
    logic [CNT_W-1:0]             o_biggest_label;
    logic [CNT_W-1:0]             o_particle_label;
    logic [BIN_W-1:0]             o_bin_count;
    logic [1:0]                   o_result_kind;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic                         i_cfg_index;
    logic [CRIT_W-1:0]            i_cfg_data;
    int                           errors;
    int                           pending;

    int send_pct;      // chance, in percent, of an idle cycle before each word
    int stall_pct;     // chance, in percent, that the receiver stalls a cycle
    int hold_left;     // long receiver hold-off, in cycles still to go
    int words_sent;
    logic [BOX_W-1:0] box_now;

    mixed_particle_cluster_labeler dut (.*);

    mpcl_checker scoreboard (.*, .o_errors(errors), .o_pending(pending));

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit, several times the longest run with every word a full frame.
    initial begin
        #50_000_000;
        $display("mixed_particle_cluster_labeler: mismatch");
        $finish;
    end

    // Receiver: stall at random, or hold off entirely while hold_left runs down.
    initial begin
        i_ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_ready = 0;
                hold_left--;
            end else begin
                i_ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one word; leave valid high after acceptance so back-to-back words
    // never drop it within a step.
    task automatic put_word(input logic [1:0] act, input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y,
                            input logic signed [COORD_BITS-1:0] z,
                            input logic [KIND_W-1:0] k, input logic last,
                            input logic [CNT_W-1:0] idx);
        while ($urandom_range(99) < send_pct) begin
            @(negedge i_clk);
            i_valid = 0;
        end
        @(negedge i_clk);
        i_action = act;
        i_pos_x = x;
        i_pos_y = y;
        i_pos_z = z;
        i_kind = k;
        i_last_particle = last;
        i_lookup_index = idx;
        i_valid = 1;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    task automatic put_load(input int x, input int y, input int z, input int k, input bit last);
        put_word(ACT_LOAD, COORD_BITS'(x), COORD_BITS'(y), COORD_BITS'(z), KIND_W'(k), last,
                 CNT_W'($urandom));
    endtask

    task automatic put_read(input logic [1:0] act, input int idx);
        put_word(act, COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
                 KIND_W'($urandom), 1'($urandom), CNT_W'(idx));
    endtask

    // Write a register only once the block is drained; a histogram clear can
    // still be running with nothing expected, so wait out its clearing pass.
    task automatic write_reg(input logic idx, input logic [CRIT_W-1:0] data);
        @(negedge i_clk);
        i_valid = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 0;
        if (idx == REG_BOX_LENGTH) box_now = data[BOX_W-1:0];
    endtask

    // One frame of n particles scattered around a random center, kinds drawn
    // from a narrow or a wide set so both pure and mixed clusters appear.
    task automatic random_frame(input int n, input int spread);
        int cx, cy, cz, kinds, x;
        cx = $urandom;
        cy = $urandom;
        cz = $urandom;
        kinds = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
            x = cx + $urandom_range(2 * spread) - spread;
            // push a few across the box so the minimum image matters
            if ($urandom_range(7) == 0) x = x + box_now;
            put_load(x, cy + $urandom_range(2 * spread) - spread,
                     cz + $urandom_range(2 * spread) - spread,
                     $urandom_range(kinds), i == n - 1);
        end
    endtask

    task automatic random_phase(input int quota, input int snd, input int stl);
        int stop_at, pick;
        send_pct = snd;
        stall_pct = stl;
        stop_at = words_sent + quota;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                random_frame($urandom_range(9) == 0 ? 24 : $urandom_range(1, 10),
                             $urandom_range(9) == 0 ? 4000 : $urandom_range(50, 900));
                repeat ($urandom_range(3))
                    put_read(ACT_READ_LABEL, $urandom_range(7) == 0 ?
                             $urandom_range(2047) : $urandom_range(12));
            end else if (pick < 80) begin
                put_read(ACT_READ_LABEL, $urandom_range(3) == 0 ?
                         $urandom_range(2047) : $urandom_range(12));
            end else if (pick < 96) begin
                put_read(ACT_READ_BIN, $urandom_range(3) == 0 ?
                         $urandom_range(2047) : $urandom_range(12));
            end else begin
                put_read(ACT_CLEAR_HIST, $urandom_range(2047));
            end
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_action = ACT_LOAD;
        i_pos_x = 0;
        i_pos_y = 0;
        i_pos_z = 0;
        i_kind = 0;
        i_last_particle = 0;
        i_lookup_index = 0;
        i_cfg_valid = 0;
        i_cfg_index = REG_BOX_LENGTH;
        i_cfg_data = 0;
        send_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        words_sent = 0;
        box_now = BOX_RESET;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: a mixed pair 2.0 apart, linked under the default cutoff.
        put_load(0, 0, 0, 0, 0);
        put_load(512, 0, 0, 1, 1);
        // Pair linked only through the periodic wrap, but of one kind: dropped.
        put_load(10, 0, 0, 2, 0);
        put_load(2550, 0, 0, 2, 1);
        // Coordinate extremes, far apart, plus a mixed pair at the far corner.
        put_load(-8388608, -8388608, -8388608, 0, 0);
        put_load(8388607, 8388607, 8388607, 3, 0);
        put_load(8388607, 8388607, 8388600, 1, 1);
        put_read(ACT_READ_LABEL, 0);
        put_read(ACT_READ_LABEL, 2);
        put_read(ACT_READ_LABEL, 1023);
        put_read(ACT_READ_LABEL, 1024);
        put_read(ACT_READ_LABEL, 2047);
        put_read(ACT_READ_BIN, 0);
        put_read(ACT_READ_BIN, 2);
        put_read(ACT_READ_BIN, 1024);
        put_read(ACT_READ_BIN, 1025);
        put_read(ACT_READ_BIN, 2047);
        put_read(ACT_CLEAR_HIST, 0);
        put_read(ACT_READ_BIN, 2);
        // Pressure: hold the receiver off so a result waits and further reads stall at the input.
        hold_left = 300;
        repeat (24) put_read(ACT_READ_BIN, $urandom_range(4));

        random_phase(135, 0, 0);
        write_reg(REG_BOX_LENGTH, CRIT_W'(0));
        write_reg(REG_CRIT_DIST_SQ, '1);
        random_phase(135, 47, 0);
        write_reg(REG_BOX_LENGTH, '1);
        write_reg(REG_CRIT_DIST_SQ, CRIT_W'(0));
        random_phase(135, 0, 47);
        write_reg(REG_BOX_LENGTH, CRIT_W'(4096));
        write_reg(REG_CRIT_DIST_SQ, CRIT_W'(640000));
        random_phase(135, 13, 13);

        @(negedge i_clk);
        i_valid = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("mixed_particle_cluster_labeler: match");
        end else begin
            $display("mixed_particle_cluster_labeler: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/mpcl_pkg.sv
src/mpcl_ram.sv
src/mixed_particle_cluster_labeler.sv
dv/mpcl_checker.sv
dv/mixed_particle_cluster_labeler_tb.sv
